// File: rtl/long_short_press_code_collector_assert.svh
// Assertion helpers for the long/short press code collector.
`ifndef LONG_SHORT_PRESS_CODE_COLLECTOR_ASSERT_SVH
`define LONG_SHORT_PRESS_CODE_COLLECTOR_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define LSPCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LSPCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/lspcc_pkg.sv
package lspcc_pkg;

    localparam int C_NUM_BUTTONS = 4;
    localparam int C_TIME_BITS   = 32;
    localparam int C_IN_BUTTONS  = 4;
    localparam int C_ACT_BUTTONS = (C_NUM_BUTTONS < C_IN_BUTTONS) ? C_NUM_BUTTONS : C_IN_BUTTONS;
    localparam int C_SUM_BITS    = $clog2(C_ACT_BUTTONS + 1);

    localparam int C_COLOR_BITS = 2;
    localparam int C_IDX_BITS   = 9;
    localparam int C_LP_BITS    = 16;
    localparam int C_CL_BITS    = 8;
    localparam int C_DATA_BITS  = 32;
    localparam int C_ADDR_BITS  = 3;

    localparam logic [C_LP_BITS-1:0] C_LONG_PRESS_RST = 16'd1000;
    localparam logic [C_CL_BITS-1:0] C_CODE_LEN_RST   = 8'd4;

    // register select, taken from paddr[2]
    localparam logic C_REG_LONG_PRESS = 1'b0;
    localparam logic C_REG_CODE_LEN   = 1'b1;

    typedef struct packed {
        logic        begin_req;
        logic        blue_down;
        logic        green_down;
        logic        yellow_down;
        logic        red_down;
        logic [31:0] now_ms;
    } t_poll;

    typedef struct packed {
        logic [C_COLOR_BITS-1:0] color;
        logic                    is_long;
        logic [C_IDX_BITS-1:0]   symbol_index;
        logic                    code_complete;
        logic                    last_of_poll;
    } t_symbol;

    // symbols produced by one poll, one bit per button
    typedef struct packed {
        logic [C_ACT_BUTTONS-1:0] emit;
        logic [C_ACT_BUTTONS-1:0] lng;
        logic [C_IDX_BITS-1:0]    base;
    } t_batch;

endpackage

// File: rtl/long_short_press_code_collector.sv
// Channel   | Direction | Handshake                      | Payload
// poll      | in        | i_poll_valid / o_poll_stall    | i_poll (t_poll)
// symbol    | out       | o_sym_valid  / i_sym_stall     | o_sym  (t_symbol)
// config    | in        | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// A poll is evaluated in the cycle it is accepted; button state and the
// symbol count update at that edge. Its symbols (0..4) leave one per cycle
// while the output is not stalled, through a batch register and an output
// register; the next poll is taken in the cycle the last symbol of the
// previous one moves to the output register.
// Reset is synchronous, active low, and clears all control state; the
// config registers return to 1000 ms and length 4.
// A stalled output holds its symbol; the batch keeps draining only when
// the output register empties.
module long_short_press_code_collector
    import lspcc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_poll_valid,
    output logic                   o_poll_stall,
    input  t_poll                  i_poll,

    output logic                   o_sym_valid,
    input  logic                   i_sym_stall,
    output t_symbol                o_sym,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [C_ADDR_BITS-1:0] paddr,
    input  logic [C_DATA_BITS-1:0] pwdata,
    output logic [C_DATA_BITS-1:0] prdata,
    output logic                   pready
);

    // ---------------- configuration registers ----------------
    logic [C_LP_BITS-1:0] r_long_press_ms;
    logic [C_CL_BITS-1:0] r_code_length;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= C_LONG_PRESS_RST;
            r_code_length   <= C_CODE_LEN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                C_REG_LONG_PRESS: r_long_press_ms <= pwdata[C_LP_BITS-1:0];
                C_REG_CODE_LEN:   r_code_length   <= pwdata[C_CL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            C_REG_LONG_PRESS: prdata = C_DATA_BITS'(r_long_press_ms);
            C_REG_CODE_LEN:   prdata = C_DATA_BITS'(r_code_length);
            default:          prdata = '0;
        endcase
    end

    // ---------------- poll evaluation ----------------
    logic   poll_acc;
    t_batch eval_batch;

    lspcc_eval u_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (poll_acc),
        .i_poll          (i_poll),
        .i_long_press_ms (r_long_press_ms),
        .i_code_length   (r_code_length),
        .o_batch         (eval_batch)
    );

    // ---------------- batch register / serializer ----------------
    logic                     r_bat_vld, n_bat_vld;
    logic [C_ACT_BUTTONS-1:0] r_bat_mask, n_bat_mask;
    logic [C_ACT_BUTTONS-1:0] r_bat_lng, n_bat_lng;
    logic [C_IDX_BITS-1:0]    r_bat_idx, n_bat_idx;

    logic                     r_out_vld, n_out_vld;
    t_symbol                  r_out, n_out;

    logic [C_ACT_BUTTONS-1:0] pick;   // lowest pending button, one-hot
    logic [C_ACT_BUTTONS-1:0] rest;
    logic                     out_free;
    logic                     move;
    logic                     bat_done;
    t_symbol                  sym;

    assign pick     = r_bat_mask & (~r_bat_mask + C_ACT_BUTTONS'(1));
    assign rest     = r_bat_mask & ~pick;
    assign out_free = !r_out_vld || !i_sym_stall;
    assign move     = r_bat_vld && out_free;
    assign bat_done = move && (rest == '0);

    assign o_poll_stall = r_bat_vld && !bat_done;
    assign poll_acc     = i_poll_valid && !o_poll_stall;

    always_comb begin
        sym.color = '0;
        for (int b = 0; b < C_ACT_BUTTONS; b++) begin
            if (pick[b]) begin
                sym.color = C_COLOR_BITS'(b);
            end
        end
        sym.is_long       = |(pick & r_bat_lng);
        sym.symbol_index  = r_bat_idx;
        // count after this symbol against the code length
        sym.code_complete = ({1'b0, r_bat_idx} + (C_IDX_BITS+1)'(1))
                            >= (C_IDX_BITS+1)'(r_code_length);
        sym.last_of_poll  = (rest == '0);
    end

    always_comb begin
        n_bat_vld  = r_bat_vld;
        n_bat_mask = r_bat_mask;
        n_bat_lng  = r_bat_lng;
        n_bat_idx  = r_bat_idx;
        if (move) begin
            n_bat_mask = rest;
            n_bat_idx  = r_bat_idx + C_IDX_BITS'(1);
            n_bat_vld  = !bat_done;
        end
        // polls that yield nothing leave the batch empty
        if (poll_acc && (eval_batch.emit != '0)) begin
            n_bat_vld  = 1'b1;
            n_bat_mask = eval_batch.emit;
            n_bat_lng  = eval_batch.lng;
            n_bat_idx  = eval_batch.base;
        end

        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (move) begin
            n_out_vld = 1'b1;
            n_out     = sym;
        end else if (r_out_vld && !i_sym_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_bat_vld <= n_bat_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bat_mask <= n_bat_mask;
        r_bat_lng  <= n_bat_lng;
        r_bat_idx  <= n_bat_idx;
        r_out      <= n_out;
    end

    assign o_sym_valid = r_out_vld;
    assign o_sym       = r_out;

endmodule

// File: rtl/lspcc_eval.sv
module lspcc_eval
    import lspcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_poll                i_poll,
    input  logic [C_LP_BITS-1:0] i_long_press_ms,
    input  logic [C_CL_BITS-1:0] i_code_length,
    output t_batch               o_batch
);

    logic [C_ACT_BUTTONS-1:0] r_held, n_held;
    logic [C_ACT_BUTTONS-1:0] r_long_sent, n_long_sent;
    logic [C_TIME_BITS-1:0]   r_press_start [C_ACT_BUTTONS];
    logic [C_TIME_BITS-1:0]   n_press_start [C_ACT_BUTTONS];
    logic [C_IDX_BITS-1:0]    r_count, n_count;

    logic [C_IN_BUTTONS-1:0]  down_vec;
    logic [C_TIME_BITS-1:0]   now_t;
    logic [C_TIME_BITS-1:0]   thresh;
    logic [C_TIME_BITS-1:0]   elapsed [C_ACT_BUTTONS];
    logic [C_IDX_BITS-1:0]    count_eff;
    logic                     ignored;
    logic [C_SUM_BITS-1:0]    n_emit;

    assign down_vec = {i_poll.red_down, i_poll.yellow_down, i_poll.green_down, i_poll.blue_down};
    assign now_t    = C_TIME_BITS'(i_poll.now_ms);
    assign thresh   = C_TIME_BITS'(i_long_press_ms);

    always_comb begin
        count_eff = i_poll.begin_req ? '0 : r_count;
        ignored   = (count_eff >= C_IDX_BITS'(i_code_length));

        n_held        = r_held;
        n_long_sent   = r_long_sent;
        n_press_start = r_press_start;
        o_batch.emit  = '0;
        o_batch.lng   = '0;
        o_batch.base  = count_eff;
        n_emit        = '0;

        for (int b = 0; b < C_ACT_BUTTONS; b++) begin
            // a fresh press counts zero elapsed time
            elapsed[b] = r_held[b] ? (now_t - r_press_start[b]) : '0;
            if (!ignored) begin
                if (down_vec[b]) begin
                    if (!r_held[b]) begin
                        n_held[b]        = 1'b1;
                        n_press_start[b] = now_t;
                    end
                    if (elapsed[b] > thresh && !r_long_sent[b]) begin
                        n_long_sent[b]  = 1'b1;
                        o_batch.emit[b] = 1'b1;
                        o_batch.lng[b]  = 1'b1;
                    end
                end else if (r_held[b]) begin
                    n_held[b] = 1'b0;
                    if (r_long_sent[b]) begin
                        n_long_sent[b] = 1'b0;
                    end else begin
                        o_batch.emit[b] = 1'b1;
                    end
                end
            end
            n_emit = n_emit + C_SUM_BITS'(o_batch.emit[b]);
        end

        n_count = count_eff + C_IDX_BITS'(n_emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_long_sent <= '0;
            r_count     <= '0;
        end else if (i_accept) begin
            r_held      <= n_held;
            r_long_sent <= n_long_sent;
            r_count     <= n_count;
        end
    end

    // press time is only read while held, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_press_start <= n_press_start;
        end
    end

endmodule

// File: rtl/lspcc_checker.sv
`include "long_short_press_code_collector_assert.svh"

module lspcc_checker
    import lspcc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_sym_valid,
    input logic    i_sym_stall,
    input t_symbol o_sym,
    input logic    pready
);

    `LSPCC_ASSERT(a_sym_hold,
        o_sym_valid && i_sym_stall |=> o_sym_valid && $stable(o_sym),
        "stalled symbol changed")

    `LSPCC_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

    // symbols of one poll leave back to back with consecutive indexes
    `LSPCC_ASSERT(a_poll_chain,
        o_sym_valid && !i_sym_stall && !o_sym.last_of_poll |=>
            o_sym_valid && (o_sym.symbol_index == $past(o_sym.symbol_index) + 9'd1),
        "poll symbols not consecutive")

    // once complete, the rest of the poll stays complete
    `LSPCC_ASSERT(a_complete_keep,
        o_sym_valid && !i_sym_stall && o_sym.code_complete && !o_sym.last_of_poll |=>
            o_sym.code_complete,
        "code_complete fell within poll")

endmodule

bind long_short_press_code_collector lspcc_checker u_lspcc_checker (.*);
